### rtl/gbn_pkg.sv
// Shared widths, data types and control bundles of the greedy box suppression unit.
`timescale 1ns / 1ps
package gbn_pkg;

	localparam int MaxBoxesDefault = 64;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int CRD_W   = 16;
	localparam int BOX_W   = 4 * CRD_W;
	localparam int SCORE_W = 16;
	localparam int LIM_W   = 16;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd32768;

	typedef struct packed {
		logic load_wr;
		logic set_n;
		logic clr_i;
		logic inc_i;
		logic clr_j;
		logic j_from_i;
		logic inc_j;
		logic rd_score_i;
		logic rd_score_j;
		logic lat_si;
		logic clr_r;
		logic cmp_r;
		logic wr_rank;
		logic rd_rank_i;
		logic rd_rank_j;
		logic lat_idx;
		logic rd_box_a;
		logic lat_a;
		logic area_a;
		logic rd_box_c;
		logic st1;
		logic st2;
		logic st3;
		logic st4;
		logic st5;
		logic emit;
		logic emit_last;
		logic clr_set;
	} gbn_cmd_t;

	typedef struct packed {
		logic load_end;
		logic i_done;
		logic j_done;
		logic rd_flagged;
		logic have_pend;
		logic out_free;
	} gbn_status_t;

endpackage

### rtl/gbn_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### rtl/gbn_dp.sv
// Datapath: box, score and rank memories, counters, IoU test and output register.
`timescale 1ns / 1ps
module gbn_dp #(
	parameter int MAX_BOXES = gbn_pkg::MaxBoxesDefault,
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gbn_pkg::gbn_cmd_t           cmd,
	output gbn_pkg::gbn_status_t        st,
	input  logic [79:0]                 in_data,
	input  logic                        in_last,
	input  logic                        cfg_valid,
	input  logic [gbn_pkg::LIM_W-1:0]   cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gbn_pkg::IDX_W-1:0]   out_index,
	output logic                        out_last
);

	localparam int CW = gbn_pkg::CNT_W;
	localparam int IW = gbn_pkg::IDX_W;

	logic [CW-1:0] cnt_q, n_q, i_q, j_q, r_q;
	logic [gbn_pkg::LIM_W-1:0] limit_q;
	logic signed [15:0] si_q;
	logic [IW-1:0] idx_q, c_q, pend_q;
	logic have_pend_q;
	logic [MAX_BOXES-1:0] flag_q;
	logic [63:0] a_q;
	logic signed [33:0] area_a_q;
	logic [15:0] iw_s1, ih_s1;
	logic signed [16:0] wb_s1, hb_s1;
	logic [31:0] inter_s2, inter_s3, inter_s4;
	logic signed [33:0] area_b_s2;
	logic signed [35:0] uni_s3, uni_s4;
	logic signed [52:0] prod_s4;
	logic out_valid_q, out_last_q;
	logic [IW-1:0] out_index_q;

	logic [AW-1:0] box_addr, score_addr, rank_addr;
	logic [63:0] box_rd;
	logic [15:0] score_rd;
	logic [IW-1:0] rank_rd;
	logic [CW-1:0] cnt_inc;
	logic signed [15:0] mn_x2, mx_x1, mn_y2, mx_y1;
	logic signed [16:0] iw17, ih17;
	logic signed [53:0] lhs, rhs;

	assign cnt_inc = cnt_q + CW'(1);

	always_comb begin
		box_addr = cnt_q[AW-1:0];
		if (cmd.rd_box_a) begin
			box_addr = idx_q[AW-1:0];
		end else if (cmd.rd_box_c) begin
			box_addr = rank_rd[AW-1:0];
		end
		score_addr = cnt_q[AW-1:0];
		if (cmd.rd_score_i) begin
			score_addr = i_q[AW-1:0];
		end else if (cmd.rd_score_j) begin
			score_addr = j_q[AW-1:0];
		end
		rank_addr = r_q[AW-1:0];
		if (cmd.rd_rank_i) begin
			rank_addr = i_q[AW-1:0];
		end else if (cmd.rd_rank_j) begin
			rank_addr = j_q[AW-1:0];
		end
	end

	gbn_ram #(.WIDTH(gbn_pkg::BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk(clk), .we(cmd.load_wr), .addr(box_addr), .wdata(in_data[63:0]), .rdata(box_rd)
	);

	gbn_ram #(.WIDTH(gbn_pkg::SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
		.clk(clk), .we(cmd.load_wr), .addr(score_addr), .wdata(in_data[79:64]),
		.rdata(score_rd)
	);

	gbn_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_rank_ram (
		.clk(clk), .we(cmd.wr_rank), .addr(rank_addr), .wdata(i_q[IW-1:0]), .rdata(rank_rd)
	);

	// Overlap edges of the kept box against the candidate just read.
	always_comb begin
		mn_x2 = ($signed(a_q[47:32]) < $signed(box_rd[47:32])) ? a_q[47:32] : box_rd[47:32];
		mn_y2 = ($signed(a_q[63:48]) < $signed(box_rd[63:48])) ? a_q[63:48] : box_rd[63:48];
		mx_x1 = ($signed(a_q[15:0]) > $signed(box_rd[15:0])) ? a_q[15:0] : box_rd[15:0];
		mx_y1 = ($signed(a_q[31:16]) > $signed(box_rd[31:16])) ? a_q[31:16] : box_rd[31:16];
		iw17 = {mn_x2[15], mn_x2} - {mx_x1[15], mx_x1};
		ih17 = {mn_y2[15], mn_y2} - {mx_y1[15], mx_y1};
		lhs = $signed({6'd0, inter_s4, 16'd0});
		rhs = {prod_s4[52], prod_s4};
	end

	always_ff @(posedge clk) begin
		if (cmd.lat_si) begin
			si_q <= score_rd;
		end
		if (cmd.lat_idx) begin
			idx_q <= rank_rd;
		end
		if (cmd.rd_box_c) begin
			c_q <= rank_rd;
		end
		if (cmd.lat_a) begin
			a_q <= box_rd;
		end
		if (cmd.area_a) begin
			area_a_q <= ($signed({a_q[47], a_q[47:32]}) - $signed({a_q[15], a_q[15:0]})) *
				($signed({a_q[63], a_q[63:48]}) - $signed({a_q[31], a_q[31:16]}));
		end
		if (cmd.st1) begin
			iw_s1 <= iw17[16] ? 16'd0 : iw17[15:0];
			ih_s1 <= ih17[16] ? 16'd0 : ih17[15:0];
			wb_s1 <= $signed({box_rd[47], box_rd[47:32]}) - $signed({box_rd[15], box_rd[15:0]});
			hb_s1 <= $signed({box_rd[63], box_rd[63:48]}) - $signed({box_rd[31], box_rd[31:16]});
		end
		if (cmd.st2) begin
			inter_s2  <= iw_s1 * ih_s1;
			area_b_s2 <= wb_s1 * hb_s1;
		end
		if (cmd.st3) begin
			uni_s3   <= 36'(area_a_q) + 36'(area_b_s2) - $signed({4'd0, inter_s2});
			inter_s3 <= inter_s2;
		end
		if (cmd.st4) begin
			prod_s4  <= $signed({1'b0, limit_q}) * uni_s3;
			uni_s4   <= uni_s3;
			inter_s4 <= inter_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			r_q         <= '0;
			limit_q     <= gbn_pkg::LIMIT_RESET;
			flag_q      <= '0;
			have_pend_q <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_index_q <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.load_wr) begin
				cnt_q <= cnt_inc;
			end
			if (cmd.set_n) begin
				n_q <= cnt_inc;
			end
			if (cmd.set_n || cmd.clr_i) begin
				i_q <= '0;
			end else if (cmd.inc_i) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.clr_j) begin
				j_q <= '0;
			end else if (cmd.j_from_i) begin
				j_q <= i_q + CW'(1);
			end else if (cmd.inc_j) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.clr_r) begin
				r_q <= '0;
			end else if (cmd.cmp_r) begin
				if ($signed(score_rd) > si_q || ($signed(score_rd) == si_q && j_q < i_q)) begin
					r_q <= r_q + CW'(1);
				end
			end
			if (cmd.st5 && uni_s4 > 36'sd0 && lhs > rhs) begin
				flag_q[c_q[AW-1:0]] <= 1'b1;
			end
			// The output register loads a new beat only when it is free.
			if (cmd.emit_last) begin
				out_valid_q <= 1'b1;
				out_index_q <= pend_q;
				out_last_q  <= 1'b1;
			end else if (cmd.emit && have_pend_q) begin
				out_valid_q <= 1'b1;
				out_index_q <= pend_q;
				out_last_q  <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				pend_q      <= idx_q;
				have_pend_q <= 1'b1;
			end else if (cmd.emit_last) begin
				have_pend_q <= 1'b0;
			end
			if (cmd.clr_set) begin
				cnt_q  <= '0;
				flag_q <= '0;
			end
		end
	end

	assign st.load_end   = in_last || (cnt_inc == CW'(MAX_BOXES));
	assign st.i_done     = (i_q == n_q);
	assign st.j_done     = (j_q == n_q);
	assign st.rd_flagged = flag_q[rank_rd[AW-1:0]];
	assign st.have_pend  = have_pend_q;
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

endmodule

### rtl/gbn_ctrl.sv
// Controller: sequences loading, ranking, the greedy walk and result hand-off.
`timescale 1ns / 1ps
module gbn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gbn_pkg::gbn_status_t st,
	output gbn_pkg::gbn_cmd_t    cmd
);

	localparam logic [4:0] S_LOAD    = 5'd0;
	localparam logic [4:0] S_RK_I    = 5'd1;
	localparam logic [4:0] S_RK_LI   = 5'd2;
	localparam logic [4:0] S_RK_J    = 5'd3;
	localparam logic [4:0] S_RK_C    = 5'd4;
	localparam logic [4:0] S_RK_WR   = 5'd5;
	localparam logic [4:0] S_RK_ICHK = 5'd6;
	localparam logic [4:0] S_W_ICHK  = 5'd7;
	localparam logic [4:0] S_W_RDR   = 5'd8;
	localparam logic [4:0] S_W_CHK   = 5'd9;
	localparam logic [4:0] S_W_RDA   = 5'd10;
	localparam logic [4:0] S_W_LDA   = 5'd11;
	localparam logic [4:0] S_W_AREA  = 5'd12;
	localparam logic [4:0] S_W_EMIT  = 5'd13;
	localparam logic [4:0] S_W_JCHK  = 5'd14;
	localparam logic [4:0] S_W_RDRJ  = 5'd15;
	localparam logic [4:0] S_W_RDB   = 5'd16;
	localparam logic [4:0] S_W_S1    = 5'd17;
	localparam logic [4:0] S_W_S2    = 5'd18;
	localparam logic [4:0] S_W_S3    = 5'd19;
	localparam logic [4:0] S_W_S4    = 5'd20;
	localparam logic [4:0] S_W_S5    = 5'd21;
	localparam logic [4:0] S_W_NEXTI = 5'd22;
	localparam logic [4:0] S_W_LAST  = 5'd23;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (st.load_end) begin
						cmd.set_n = 1'b1;
						state_d   = S_RK_I;
					end
				end
			end
			S_RK_I: begin
				cmd.rd_score_i = 1'b1;
				cmd.clr_r      = 1'b1;
				cmd.clr_j      = 1'b1;
				state_d        = S_RK_LI;
			end
			S_RK_LI: begin
				cmd.lat_si = 1'b1;
				state_d    = S_RK_J;
			end
			S_RK_J: begin
				if (st.j_done) begin
					state_d = S_RK_WR;
				end else begin
					cmd.rd_score_j = 1'b1;
					state_d        = S_RK_C;
				end
			end
			S_RK_C: begin
				cmd.cmp_r = 1'b1;
				cmd.inc_j = 1'b1;
				state_d   = S_RK_J;
			end
			S_RK_WR: begin
				cmd.wr_rank = 1'b1;
				cmd.inc_i   = 1'b1;
				state_d     = S_RK_ICHK;
			end
			S_RK_ICHK: begin
				if (st.i_done) begin
					cmd.clr_i = 1'b1;
					state_d   = S_W_ICHK;
				end else begin
					state_d = S_RK_I;
				end
			end
			S_W_ICHK: begin
				state_d = st.i_done ? S_W_LAST : S_W_RDR;
			end
			S_W_RDR: begin
				cmd.rd_rank_i = 1'b1;
				state_d       = S_W_CHK;
			end
			S_W_CHK: begin
				cmd.lat_idx = 1'b1;
				if (st.rd_flagged) begin
					cmd.inc_i = 1'b1;
					state_d   = S_W_ICHK;
				end else begin
					state_d = S_W_RDA;
				end
			end
			S_W_RDA: begin
				cmd.rd_box_a = 1'b1;
				state_d      = S_W_LDA;
			end
			S_W_LDA: begin
				cmd.lat_a = 1'b1;
				state_d   = S_W_AREA;
			end
			S_W_AREA: begin
				cmd.area_a = 1'b1;
				state_d    = S_W_EMIT;
			end
			S_W_EMIT: begin
				if (!st.have_pend || st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.j_from_i = 1'b1;
					state_d      = S_W_JCHK;
				end
			end
			S_W_JCHK: begin
				state_d = st.j_done ? S_W_NEXTI : S_W_RDRJ;
			end
			S_W_RDRJ: begin
				cmd.rd_rank_j = 1'b1;
				state_d       = S_W_RDB;
			end
			S_W_RDB: begin
				cmd.rd_box_c = 1'b1;
				state_d      = S_W_S1;
			end
			S_W_S1: begin
				cmd.st1 = 1'b1;
				state_d = S_W_S2;
			end
			S_W_S2: begin
				cmd.st2 = 1'b1;
				state_d = S_W_S3;
			end
			S_W_S3: begin
				cmd.st3 = 1'b1;
				state_d = S_W_S4;
			end
			S_W_S4: begin
				cmd.st4 = 1'b1;
				state_d = S_W_S5;
			end
			S_W_S5: begin
				cmd.st5   = 1'b1;
				cmd.inc_j = 1'b1;
				state_d   = S_W_JCHK;
			end
			S_W_NEXTI: begin
				cmd.inc_i = 1'b1;
				state_d   = S_W_ICHK;
			end
			S_W_LAST: begin
				if (st.out_free) begin
					cmd.emit_last = 1'b1;
					cmd.clr_set   = 1'b1;
					state_d       = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

### rtl/greedy_box_nms_unit.sv
// Top level of the greedy non-maximum suppression unit.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: x1,y1,x2,y2,score; tlast: last box of set
// m_*       out  m_tvalid/m_tready  tdata: kept index; tlast: last kept index of set
// cfg_*     in   cfg_valid/cfg_ready IoU limit, unsigned Q0.16
//
// Loading takes one box beat per cycle. When a set of N boxes closes, it is ranked on
// the single score memory port, and the greedy walk tests each (kept box, later box)
// pair on the box memory port and the IoU stages.
// Reset clears the counters, suppression flags and output register; the IoU limit
// returns to one half. No box beat is taken while a set is being ranked or walked, and
// the walk stalls at each kept box on an untaken output beat if an earlier kept index is pending.
`timescale 1ns / 1ps
module greedy_box_nms_unit #(
	parameter int MAX_BOXES = gbn_pkg::MaxBoxesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// From bit 0 up: corner_x1, corner_y1, corner_x2, corner_y2, box_score.
	input  logic [79:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// From bit 0 up: kept_index, then two zero pad bits.
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	gbn_pkg::gbn_cmd_t    cmd;
	gbn_pkg::gbn_status_t st;
	logic [gbn_pkg::IDX_W-1:0] kept_index;

	// The limit register may be written in any cycle.
	assign cfg_ready = 1'b1;

	gbn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.st(st), .cmd(cmd)
	);

	gbn_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.in_data(s_tdata), .in_last(s_tlast),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_index(kept_index), .out_last(m_tlast)
	);

	assign m_tdata = {2'b00, kept_index};

endmodule

### test/greedy_box_nms_unit_checker.sv
// Watches the box, result and limit channels, predicts the kept indexes and compares them.
`timescale 1ns / 1ps
module greedy_box_nms_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [gbn_pkg::IDX_W-1:0] kept_index;
		logic                      final_kept;
	} kept_beat_t;

	logic signed [15:0] x1_mem [64];
	logic signed [15:0] y1_mem [64];
	logic signed [15:0] x2_mem [64];
	logic signed [15:0] y2_mem [64];
	logic signed [15:0] score_mem [64];
	logic [gbn_pkg::LIM_W-1:0] iou_thr;
	int n_boxes;
	kept_beat_t kept_q [$];

	function automatic longint lmin(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return a > b ? a : b;
	endfunction

	// Division-free IoU test between two stored boxes.
	function automatic bit iou_exceeds(int a, int b);
		longint iw, ih, inter, uni, area_a, area_b;
		iw = lmin(x2_mem[a], x2_mem[b]) - lmax(x1_mem[a], x1_mem[b]);
		ih = lmin(y2_mem[a], y2_mem[b]) - lmax(y1_mem[a], y1_mem[b]);
		if (iw < 0) iw = 0;
		if (ih < 0) ih = 0;
		inter = iw * ih;
		area_a = (longint'(x2_mem[a]) - x1_mem[a]) * (longint'(y2_mem[a]) - y1_mem[a]);
		area_b = (longint'(x2_mem[b]) - x1_mem[b]) * (longint'(y2_mem[b]) - y1_mem[b]);
		uni = area_a + area_b - inter;
		if (uni <= 0) return 0;
		return inter * 65536 > longint'(iou_thr) * uni;
	endfunction

	// Ranks the set by score and walks it greedily, queueing each kept index.
	function automatic void predict_kept();
		int rank [64];
		bit gone [64];
		int r, kept, idx;
		kept_beat_t beat;
		kept = 0;
		for (int i = 0; i < n_boxes; i++) begin
			r = 0;
			gone[i] = 0;
			for (int j = 0; j < n_boxes; j++)
				if (score_mem[j] > score_mem[i] || (score_mem[j] == score_mem[i] && j < i))
					r++;
			rank[r] = i;
		end
		for (int i = 0; i < n_boxes; i++) begin
			idx = rank[i];
			if (!gone[idx]) begin
				beat.kept_index = idx[5:0];
				beat.final_kept = 1'b0;
				kept_q.insert(kept_q.size(), beat);
				kept++;
				for (int j = i + 1; j < n_boxes; j++)
					if (iou_exceeds(idx, rank[j]))
						gone[rank[j]] = 1;
			end
		end
		kept_q[kept_q.size() - 1].final_kept = 1'b1;
		n_boxes = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kept_beat_t want;
		if (!arst_n) begin
			iou_thr = gbn_pkg::LIMIT_RESET;
			n_boxes = 0;
			kept_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (kept_q.size() == 0) begin
					$error("unexpected result beat: kept_index %0d", m_tdata[5:0]);
					fail_count <= fail_count + 1;
				end else begin
					want = kept_q.pop_front();
					if (m_tdata[5:0] !== want.kept_index) begin
						$error("kept_index: expected %0d, actual %0d",
							want.kept_index, m_tdata[5:0]);
						fail_count <= fail_count + 1;
					end else if (m_tlast !== want.final_kept) begin
						$error("final_kept: expected %0d, actual %0d",
							want.final_kept, m_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				iou_thr = cfg_data;
			if (s_tvalid && s_tready) begin
				x1_mem[n_boxes] = s_tdata[15:0];
				y1_mem[n_boxes] = s_tdata[31:16];
				x2_mem[n_boxes] = s_tdata[47:32];
				y2_mem[n_boxes] = s_tdata[63:48];
				score_mem[n_boxes] = s_tdata[79:64];
				n_boxes++;
				if (s_tlast || n_boxes >= 64)
					predict_kept();
			end
			pending <= kept_q.size();
		end
	end

endmodule

### test/greedy_box_nms_unit_tb.sv
// Stimulus, clock, reset and verdict for the greedy box suppression unit.
`timescale 1ns / 1ps
module greedy_box_nms_unit_tb;

	localparam int WatchdogLimit = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// From bit 0 up: corner_x1, corner_y1, corner_x2, corner_y2, box_score.
	logic [79:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	// From bit 0 up: kept_index, then two zero pad bits.
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int tx_idle_pct;
	int rx_stall_pct;
	int boxes_sent;
	int quiet_cycles;

	greedy_box_nms_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	greedy_box_nms_unit_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver stalls at random with the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// A long stretch with no beat on any channel means the unit has hung.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("greedy_box_nms_unit_tb NOT OK");
			$finish;
		end
	end

	// Sends one box beat, idling beforehand at the phase's rate. Valid stays
	// high after the handshake so back-to-back beats need no extra edge.
	task automatic send_box(input int x1, input int y1, input int x2, input int y2,
			input int score, input logic last_box);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {16'(score), 16'(y2), 16'(x2), 16'(y1), 16'(x1)};
		s_tlast  <= last_box;
		do @(posedge clk); while (!s_tready);
		boxes_sent++;
	endtask

	// Waits until every predicted kept index has been taken, plus the time the
	// unit needs to clear its set state after the last beat.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Boxes cluster around a center so that many pairs overlap; now and then a
	// box takes fully random corners, which may be inverted or huge.
	task automatic send_random_set(input int count, input bit close_with_last);
		int cx, cy, w, h, sc;
		cx = $urandom_range(400) - 200;
		cy = $urandom_range(400) - 200;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(7) == 0) begin
				send_box($urandom, $urandom, $urandom, $urandom, $urandom,
					close_with_last && k == count - 1);
			end else begin
				w = $urandom_range(60);
				h = $urandom_range(60);
				sc = ($urandom_range(3) == 0) ? $urandom : $urandom_range(12);
				send_box(cx + $urandom_range(20) - 10, cy + $urandom_range(20) - 10,
					cx + w, cy + h, sc, close_with_last && k == count - 1);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet_cycles = 0;
		boxes_sent = 0;
		tx_idle_pct = 6;
		rx_stall_pct = 68;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the highest limit: suppression needs an IoU above 65535/65536.
		write_limit(16'hFFFF);
		// One box spanning the whole coordinate range closes a set by itself.
		send_box(-32768, -32768, 32767, 32767, 32767, 1'b1);
		// Identical boxes on a score tie, an inverted box, a flat box, lowest score.
		send_box(10, 10, 50, 50, 5, 1'b0);
		send_box(10, 10, 50, 50, 5, 1'b0);
		send_box(50, 10, 10, 50, 9, 1'b0);
		send_box(-20, -20, -20, 40, 7, 1'b0);
		send_box(32767, 32767, -32768, -32768, -32768, 1'b1);
		// Disjoint boxes and a box nested in another.
		send_box(0, 0, 10, 10, 1, 1'b0);
		send_box(100, 100, 200, 200, 3, 1'b0);
		send_box(120, 120, 130, 130, 2, 1'b0);
		send_box(-300, -300, -250, -250, -1, 1'b1);
		wait_drained();
		// Any overlap at all suppresses at limit zero.
		write_limit(16'h0000);
		send_box(0, 0, 20, 20, 4, 1'b0);
		send_box(19, 19, 40, 40, 3, 1'b0);
		send_box(20, 20, 40, 40, 2, 1'b0);
		send_box(50, 0, 30, 20, 1, 1'b1);
		wait_drained();

		// Three random phases with different idle patterns and limits.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 6;
					rx_stall_pct = 68;
					write_limit(16'd32768);
				end
				1: begin
					tx_idle_pct = 68;
					rx_stall_pct = 6;
					write_limit(16'($urandom));
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					write_limit(16'($urandom_range(16'h6000)));
				end
			endcase
			// A full store closes the set without a last flag.
			if (phase != 1)
				send_random_set(64, 1'b0);
			while (boxes_sent < 25 + (phase + 1) * 135) begin
				send_random_set($urandom_range(1, 8), 1'b1);
				if (phase == 0 && boxes_sent > 120 && boxes_sent < 130)
					wait_drained();
			end
			wait_drained();
		end

		if (fail_count == 0 && pending == 0)
			$display("greedy_box_nms_unit_tb OK");
		else
			$display("greedy_box_nms_unit_tb NOT OK");
		$finish;
	end

endmodule
